>>> rtl/tbd_pkg.sv
// ----------------------------------------------------------------------------
// tbd_pkg
// Shared types, codes and decode helpers for the token byte decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tbd_pkg;

  localparam int MAX_TOKEN_BYTES_DEF = 64;

  // vocab_mode codes
  localparam logic [1:0] MODE_RAW       = 2'd0;
  localparam logic [1:0] MODE_FALLBACK  = 2'd1;
  localparam logic [1:0] MODE_BYTELEVEL = 2'd2;

  // out_error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_HEX  = 2'd1;
  localparam logic [1:0] ERR_OVF  = 2'd2;

  // register byte address
  localparam logic [2:0] ADDR_VOCAB_MODE = 3'd0;

  localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_X     = 8'h78;  // 'x'
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] SP_B0    = 8'hE2;
  localparam logic [7:0] SP_B1    = 8'h96;
  localparam logic [7:0] SP_B2    = 8'h81;
  localparam int         MAP_SIZE = 324;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT, S_HEX} bk_state_t;
  typedef enum logic [1:0] {K_PLAIN, K_REPL, K_UTF} emit_kind_t;

  typedef struct packed {
    logic [1:0]  rem;   // continuation bytes still expected
    logic [1:0]  len;   // sequence length minus one
    logic [20:0] cp;
    logic        done;  // codepoint complete on this byte
    logic        bad;
    logic [7:0]  val;   // mapped byte when done
  } utf_t;

  // inverse byte-to-unicode map: {ok, byte}
  function automatic logic [8:0] inv_map(input logic [20:0] cp);
    logic [6:0] k;
    logic [8:0] r;
    k = 7'(cp - 21'd256);
    r = '0;
    if (cp >= 21'(MAP_SIZE)) begin
      r = '0;
    end else if (cp < 21'd256) begin
      if ((cp >= 21'd33 && cp <= 21'd126) || (cp >= 21'd161 && cp <= 21'd172) ||
          cp >= 21'd174) begin
        r = {1'b1, cp[7:0]};
      end
    end else if (k <= 7'd32) begin
      r = {1'b1, 1'b0, k};
    end else if (k <= 7'd66) begin
      r = {1'b1, 8'({1'b0, k} + 8'd94)};
    end else begin
      r = {1'b1, 8'd173};
    end
    return r;
  endfunction

  // one byte of strict UTF-8 decoding
  function automatic utf_t utf_step(input logic [1:0] rem, input logic [1:0] len,
                                    input logic [20:0] cp, input logic [7:0] d);
    utf_t r;
    logic [8:0] mp;
    r.rem = rem; r.len = len; r.cp = cp; r.done = 1'b0; r.bad = 1'b0; r.val = '0;
    if (rem == 2'd0) begin
      priority if (d[7] == 1'b0) begin
        r.len = 2'd0; r.cp = {13'd0, d}; r.done = 1'b1;
      end else if (d[7:5] == 3'b110) begin
        r.len = 2'd1; r.rem = 2'd1; r.cp = {16'd0, d[4:0]};
      end else if (d[7:4] == 4'b1110) begin
        r.len = 2'd2; r.rem = 2'd2; r.cp = {17'd0, d[3:0]};
      end else if (d[7:3] == 5'b11110) begin
        r.len = 2'd3; r.rem = 2'd3; r.cp = {18'd0, d[2:0]};
      end else begin
        r.bad = 1'b1;
      end
    end else begin
      if (d[7:6] != 2'b10) begin
        r.bad = 1'b1;
      end else begin
        r.cp   = {cp[14:0], d[5:0]};
        r.rem  = rem - 2'd1;
        r.done = (rem == 2'd1);
      end
    end
    mp = inv_map(r.cp);
    if (r.done) begin
      // overlong forms
      if ((r.len == 2'd1 && r.cp < 21'h80) || (r.len == 2'd2 && r.cp < 21'h800) ||
          (r.len == 2'd3 && r.cp < 21'h10000)) begin
        r.bad = 1'b1;
      end
      if (!mp[8]) begin
        r.bad = 1'b1;
      end
      r.val = mp[7:0];
    end
    return r;
  endfunction

  function automatic logic signed [8:0] hex_digit(input logic [7:0] c);
    logic signed [8:0] r;
    if (c >= CH_ZERO && c <= CH_NINE) r = $signed({1'b0, c}) - 9'sd48;
    else r = $signed({1'b0, c}) - 9'sd55;
    return r;
  endfunction

  // d0*16 + d1, signed
  function automatic logic signed [12:0] hex_val(input logic [7:0] c0, input logic [7:0] c1);
    logic signed [12:0] a;
    logic signed [12:0] b;
    a = 13'(hex_digit(c0));
    b = 13'(hex_digit(c1));
    return (a <<< 4) + b;
  endfunction

endpackage

>>> rtl/tbd_queue.sv
// ----------------------------------------------------------------------------
// tbd_queue
// Two-entry descriptor queue between the collecting front and the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbd_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic         valid,
  output logic         full,
  output logic [W-1:0] dout
);

  logic [W-1:0] entry [0:1];
  logic         rd_ptr;
  logic         wr_ptr;
  logic [1:0]   cnt;

  assign valid = (cnt != 2'd0);
  assign full  = (cnt == 2'd2);
  assign dout  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      cnt <= 2'(cnt + {1'b0, push} - {1'b0, pop});
    end
  end

endmodule

>>> rtl/tbd_front.sv
// ----------------------------------------------------------------------------
// tbd_front
// Accepts token bytes, writes them to the free buffer bank, queues tokens.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbd_front #(
  parameter int  MAX_TOKEN_BYTES = tbd_pkg::MAX_TOKEN_BYTES_DEF,
  localparam int IW = $clog2(MAX_TOKEN_BYTES),
  localparam int CW = $clog2(MAX_TOKEN_BYTES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  input  logic          rel,       // decoder finished with a bank
  output logic          wr_en,
  output logic          wr_bank,
  output logic [IW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output logic          push,
  output logic          push_bank,
  output logic [CW-1:0] push_n,
  output logic          push_ovf
);

  logic [CW-1:0] count;
  logic          ovf;
  logic          wbank;
  logic [1:0]    busy;   // tokens queued or being decoded
  logic          accept;
  logic          room;

  assign in_ready  = (busy != 2'd2);
  assign accept    = in_valid && in_ready;
  assign room      = (count < CW'(MAX_TOKEN_BYTES));
  assign wr_en     = accept && room;
  assign wr_bank   = wbank;
  assign wr_addr   = count[IW-1:0];
  assign wr_data   = in_byte;
  assign push      = accept && in_last;
  assign push_bank = wbank;
  assign push_n    = room ? CW'(count + CW'(1)) : count;
  assign push_ovf  = ovf || !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
      wbank <= 1'b0;
      busy  <= 2'd0;
    end else begin
      busy <= 2'(busy + {1'b0, push} - {1'b0, rel});
      if (accept) begin
        if (in_last) begin
          count <= '0;
          ovf   <= 1'b0;
          wbank <= ~wbank;
        end else if (room) begin
          count <= CW'(count + CW'(1));
        end else begin
          ovf <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/tbd_back.sv
// ----------------------------------------------------------------------------
// tbd_back
// Token buffer and decode sequencer: optional scan pass, then emit pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbd_back #(
  parameter int  MAX_TOKEN_BYTES = tbd_pkg::MAX_TOKEN_BYTES_DEF,
  localparam int IW = $clog2(MAX_TOKEN_BYTES),
  localparam int CW = $clog2(MAX_TOKEN_BYTES + 1),
  localparam int XW = CW + 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    vocab_mode,
  input  logic          wr_en,
  input  logic          wr_bank,
  input  logic [IW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          desc_valid,
  input  logic          desc_bank,
  input  logic [CW-1:0] desc_n,
  input  logic          desc_ovf,
  output logic          desc_pop,
  output logic          rel,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_last,
  output logic [1:0]    out_error
);

  logic [7:0] mem [0:1][0:MAX_TOKEN_BYTES-1];
  logic [7:0] q;
  // space-marker start flags, one per buffer position, written during scan
  logic       hit_mem [0:MAX_TOKEN_BYTES-1];
  logic       hit_q;

  tbd_pkg::bk_state_t  st, st_next;
  tbd_pkg::emit_kind_t kind, kind_next;
  logic                bank, bank_next;
  logic [CW-1:0]       n, n_next;
  logic [1:0]          err, err_next;
  logic [XW-1:0]       idx, idx_next;
  logic [1:0]          rem, rem_next;
  logic [1:0]          len, len_next;
  logic [20:0]         cp, cp_next;
  logic                ubad, ubad_next;
  logic                hpat, hpat_next;
  logic [7:0]          hb3, hb3_next, hb4, hb4_next;
  logic [7:0]          w1, w1_next, w2, w2_next;

  tbd_pkg::utf_t       step;
  logic                can_load, load, ld_last;
  logic [7:0]          ld_byte;
  logic [1:0]          ld_err;
  logic                hit_we, hit_wd;
  logic [IW-1:0]       hit_wa;
  logic                scan_end, hex_final, utf_fail;
  logic                fb_mode, bl_mode;
  logic [XW-1:0]       idx_p1, idx_p3, idx_m2, n_x;
  logic signed [12:0]  hx;

  assign fb_mode   = (vocab_mode == tbd_pkg::MODE_FALLBACK);
  assign bl_mode   = (vocab_mode == tbd_pkg::MODE_BYTELEVEL);
  assign can_load  = !out_valid || out_ready;
  assign n_x       = XW'(n);
  assign idx_p1    = XW'(idx + XW'(1));
  assign idx_p3    = XW'(idx + XW'(3));
  assign idx_m2    = XW'(idx - XW'(2));
  assign scan_end  = (idx_p1 == n_x);
  assign step      = tbd_pkg::utf_step(rem, len, cp, q);
  assign hex_final = (n == CW'(6)) && hpat && (q == tbd_pkg::CH_GT);
  assign utf_fail  = ubad || step.bad || (step.rem != 2'd0);
  assign hx        = tbd_pkg::hex_val(hb3, hb4);

  always_comb begin
    st_next = st;
    unique case (st)
      tbd_pkg::S_IDLE: begin
        if (desc_valid) begin
          st_next = (fb_mode || bl_mode) ? tbd_pkg::S_SCAN : tbd_pkg::S_EMIT;
        end
      end
      tbd_pkg::S_SCAN: begin
        if (scan_end) begin
          st_next = (fb_mode && hex_final) ? tbd_pkg::S_HEX : tbd_pkg::S_EMIT;
        end
      end
      tbd_pkg::S_EMIT: begin
        if (load && ld_last) st_next = tbd_pkg::S_IDLE;
      end
      tbd_pkg::S_HEX: begin
        if (can_load) st_next = tbd_pkg::S_IDLE;
      end
      default: st_next = tbd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    kind_next = kind; bank_next = bank; n_next = n; err_next = err;
    idx_next = idx; rem_next = rem; len_next = len; cp_next = cp;
    ubad_next = ubad; hpat_next = hpat; hb3_next = hb3; hb4_next = hb4;
    w1_next = w1; w2_next = w2;
    hit_we = 1'b0; hit_wd = 1'b0; hit_wa = idx_m2[IW-1:0];
    desc_pop = 1'b0; load = 1'b0; ld_last = 1'b0; ld_byte = q; ld_err = err;
    unique case (st)
      tbd_pkg::S_IDLE: begin
        if (desc_valid) begin
          desc_pop  = 1'b1;
          bank_next = desc_bank;
          n_next    = desc_n;
          err_next  = desc_ovf ? tbd_pkg::ERR_OVF : tbd_pkg::ERR_NONE;
          idx_next  = '0;
          rem_next  = '0;
          len_next  = '0;
          cp_next   = '0;
          ubad_next = 1'b0;
          hpat_next = 1'b1;
          kind_next = tbd_pkg::K_PLAIN;
        end
      end
      tbd_pkg::S_SCAN: begin
        idx_next  = idx_p1;
        rem_next  = step.rem;
        len_next  = step.len;
        cp_next   = step.cp;
        ubad_next = ubad || step.bad;
        w1_next   = q;
        w2_next   = w1;
        // every position that can start a marker gets its flag rewritten
        hit_we = (idx >= XW'(2));
        hit_wd = (w2 == tbd_pkg::SP_B0 && w1 == tbd_pkg::SP_B1 &&
                  q == tbd_pkg::SP_B2);
        if ((idx == XW'(0) && q != tbd_pkg::CH_LT) ||
            (idx == XW'(1) && q != tbd_pkg::CH_ZERO) ||
            (idx == XW'(2) && q != tbd_pkg::CH_X)) begin
          hpat_next = 1'b0;
        end
        if (idx == XW'(3)) hb3_next = q;
        if (idx == XW'(4)) hb4_next = q;
        if (scan_end) begin
          idx_next = '0;
          rem_next = '0;
          len_next = '0;
          cp_next  = '0;
          if (fb_mode) kind_next = tbd_pkg::K_REPL;
          else kind_next = utf_fail ? tbd_pkg::K_PLAIN : tbd_pkg::K_UTF;
        end
      end
      tbd_pkg::S_EMIT: begin
        if (can_load) begin
          unique case (kind)
            tbd_pkg::K_REPL: begin
              load = 1'b1;
              // flags past n - 3 are stale from older tokens
              if (hit_q && idx_p3 <= n_x) begin
                ld_byte  = tbd_pkg::CH_SPACE;
                ld_last  = (idx_p3 == n_x);
                idx_next = idx_p3;
              end else begin
                ld_last  = (idx_p1 == n_x);
                idx_next = idx_p1;
              end
            end
            tbd_pkg::K_UTF: begin
              rem_next = step.rem;
              len_next = step.len;
              cp_next  = step.cp;
              load     = step.done;
              ld_byte  = step.val;
              ld_last  = (idx_p1 == n_x);
              idx_next = idx_p1;
            end
            default: begin
              load     = 1'b1;
              ld_last  = (idx_p1 == n_x);
              idx_next = idx_p1;
            end
          endcase
        end
      end
      tbd_pkg::S_HEX: begin
        if (can_load) begin
          load    = 1'b1;
          ld_last = 1'b1;
          ld_byte = hx[7:0];
          if (hx[12] || hx[11:8] != 4'd0) ld_err = tbd_pkg::ERR_HEX;
        end
      end
      default: ;
    endcase
  end

  assign rel = load && ld_last;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_bank][wr_addr] <= wr_data;
    end
    q <= mem[bank_next][idx_next[IW-1:0]];
  end

  // last scan write can hit the address read for the first emit cycle
  always_ff @(posedge clk) begin
    if (hit_we) begin
      hit_mem[hit_wa] <= hit_wd;
    end
    if (hit_we && hit_wa == idx_next[IW-1:0]) begin
      hit_q <= hit_wd;
    end else begin
      hit_q <= hit_mem[idx_next[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= tbd_pkg::S_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    kind <= kind_next; bank <= bank_next; n <= n_next; err <= err_next;
    idx <= idx_next; rem <= rem_next; len <= len_next;
    cp <= cp_next; ubad <= ubad_next; hpat <= hpat_next;
    hb3 <= hb3_next; hb4 <= hb4_next; w1 <= w1_next; w2 <= w2_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= ld_byte;
      out_last  <= ld_last;
      out_error <= ld_err;
    end
  end

  a_rel_shows_last: assert property (@(posedge clk) disable iff (rst)
    rel |=> out_valid && out_last)
    else $error("bank released without final item in output register");

  a_hex_six: assert property (@(posedge clk) disable iff (rst)
    (st == tbd_pkg::S_HEX) |-> (n == CW'(6)))
    else $error("hex path taken on a token that is not six bytes");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (st == tbd_pkg::S_SCAN) |-> (idx < n_x))
    else $error("scan index ran past token length");

endmodule

>>> rtl/token_byte_decoder.sv
// ----------------------------------------------------------------------------
// token_byte_decoder
// Collects one vocabulary token byte by byte and emits its decoded bytes.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream s_*: one token byte per item, s_tlast on its final byte.
//  - Master stream m_*: decoded bytes, m_tlast on the final one, m_tuser
//    carries the error code (same on every item of a token).
//  - APB port: vocab_mode at address 0 (0 raw, 1 byte fallback, 2 byte level,
//    3 acts as raw). Write only while the block is idle.
//  - Input takes one byte per cycle. Two buffer banks ping-pong, so the
//    next token collects while the previous one decodes; the input stalls
//    only when both banks hold tokens not yet fully emitted.
//  - Decode: raw mode emits one byte per cycle while the receiver accepts.
//    Fallback and byte-level modes first scan the token (one buffer read
//    per cycle), then emit; byte level emits one byte per completed
//    codepoint, or the token's raw bytes if it is not valid UTF-8.
//  - Synchronous reset empties the banks and the queue; no clearing pass.
//  - A stalled receiver holds the output register and stalls the emit pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module token_byte_decoder #(
  parameter int  MAX_TOKEN_BYTES = tbd_pkg::MAX_TOKEN_BYTES_DEF,
  localparam int IW = $clog2(MAX_TOKEN_BYTES),
  localparam int CW = $clog2(MAX_TOKEN_BYTES + 1)
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,
  output logic [1:0]  m_tuser,   // [1:0] out_error
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DW = CW + 2;  // descriptor: {bank, ovf, n}

  logic [1:0]    vocab_mode;
  logic          rel;
  logic          wr_en, wr_bank;
  logic [IW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          push, push_bank, push_ovf;
  logic [CW-1:0] push_n;
  logic          q_valid, q_full, q_pop;
  logic [DW-1:0] q_dout;

  // config register
  assign pready = 1'b1;
  assign prdata = (paddr == tbd_pkg::ADDR_VOCAB_MODE) ? {30'd0, vocab_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vocab_mode <= tbd_pkg::MODE_RAW;
    end else if (psel && penable && pwrite && pready &&
                 paddr == tbd_pkg::ADDR_VOCAB_MODE) begin
      vocab_mode <= pwdata[1:0];
    end
  end

  tbd_front #(.MAX_TOKEN_BYTES(MAX_TOKEN_BYTES)) u_front (
    .clk, .rst,
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .rel,
    .wr_en, .wr_bank, .wr_addr, .wr_data,
    .push, .push_bank, .push_n, .push_ovf
  );

  // q_full never rises here: front holds at most two outstanding tokens
  tbd_queue #(.W(DW)) u_queue (
    .clk, .rst,
    .push,
    .din   ({push_bank, push_ovf, push_n}),
    .pop   (q_pop),
    .valid (q_valid),
    .full  (q_full),
    .dout  (q_dout)
  );

  tbd_back #(.MAX_TOKEN_BYTES(MAX_TOKEN_BYTES)) u_back (
    .clk, .rst,
    .vocab_mode,
    .wr_en, .wr_bank, .wr_addr, .wr_data,
    .desc_valid (q_valid && !(push && q_full)),
    .desc_bank  (q_dout[DW-1]),
    .desc_n     (q_dout[CW-1:0]),
    .desc_ovf   (q_dout[CW]),
    .desc_pop   (q_pop),
    .rel,
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (m_tdata),
    .out_last   (m_tlast),
    .out_error  (m_tuser)
  );

endmodule
